[design/gws_pkg.sv]
// Shared constants, types and register codes of the grid word search counter.
package gws_pkg;

  localparam int MAX_COLS  = 256;
  localparam int WORD_LEN  = 4;
  localparam int HIST      = WORD_LEN - 1;
  localparam int CELLS     = 2 * HIST + 1;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int LEN_W     = COL_W + 1;
  localparam int TOTAL_W   = 24;
  localparam int CNT_W     = 2;
  localparam int FOUND_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = {TOTAL_W{1'b1}};
  localparam logic [LEN_W-1:0]   ROW_LEN_RESET  = LEN_W'(256);
  localparam logic [CFG_W-1:0]   WORD_RESET     = 32'h5341_4D58;

  typedef logic [7:0] char_t;
  // One column of the rows above: entry k-1 holds the row k above.
  typedef char_t [HIST-1:0] col_t;
  // First columns of a row, kept for reloading the window at a row start.
  typedef char_t [HIST:0] head_t;
  typedef char_t [WORD_LEN-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH = 1'b0,
    REG_WORD_CHARS = 1'b1
  } cfg_reg_t;

endpackage

[design/gws_line_ram.sv]
// Line store: one row of characters, one write and one registered read a cycle.
module gws_line_ram
  import gws_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  char_t            wdata,
  input  logic             re,
  input  logic [COL_W-1:0] raddr,
  output char_t            rdata
);

  char_t mem [MAX_COLS];
  char_t rd_r;
  char_t byp_data_r;
  logic  byp_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r       <= mem[raddr];
      byp_r      <= we && (waddr == raddr);
      byp_data_r <= wdata;
    end
  end

  // A read of the entry written in the same cycle returns the new data.
  assign rdata = byp_r ? byp_data_r : rd_r;

endmodule

[design/gws_col_cell.sv]
// One column cell of the search window: the characters of the rows above at one offset.
module gws_col_cell
  import gws_pkg::*;
(
  input  logic clk,
  input  logic shift_en,
  input  logic load_en,
  input  col_t shift_in,
  input  col_t load_in,
  output col_t col_q
);

  col_t col_r;
  col_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (load_en) begin
      col_nxt = load_in;
    end else if (shift_en) begin
      col_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end

  assign col_q = col_r;

endmodule

[design/gws_window_test.sv]
// Compares one window against the word, forward and reversed.
module gws_window_test
  import gws_pkg::*;
(
  input  word_t            win,
  input  word_t            word,
  input  logic             en,
  output logic [CNT_W-1:0] cnt
);

  logic fwd;
  logic rev;

  always_comb begin
    fwd = 1'b1;
    rev = 1'b1;
    for (int i = 0; i < WORD_LEN; i++) begin
      if (win[i] != word[i]) begin
        fwd = 1'b0;
      end
      if (win[i] != word[WORD_LEN-1-i]) begin
        rev = 1'b0;
      end
    end
    cnt = en ? (CNT_W'(fwd) + CNT_W'(rev)) : '0;
  end

endmodule

[design/grid_word_search_counter_unit.sv]
// Eight-direction word search counter: the grid arrives as a raster of one character per item,
// and the block takes one item every clock while in_stall is low, at any row length from 1 to
// 256. Each cell is tested the cycle it arrives against the horizontal, vertical and both diagonal
// windows that end there; the three rows above come from one line store each (one write and one
// read port), whose reads run five columns ahead into a seven-column chain of window cells, so the
// flow does not pause at a row edge. The count is registered into the output stage when the item
// marked as the grid end is accepted, and a second result is held in a skid stage while the first
// waits. Line stores need no clearing after reset; a new grid is searched vertically only once
// three of its rows have arrived.
module grid_word_search_counter_unit
  import gws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_cell_char,
  input  logic                 in_grid_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TOTAL_W-1:0]   out_match_total,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration.
  logic [LEN_W-1:0] row_length_r;
  logic [CFG_W-1:0] word_chars_r;
  logic [LEN_W-1:0] eff_len;
  word_t            word;

  // Per-grid control.
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [1:0]         rows_seen_r, rows_seen_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               in_acc;
  logic               row_last;
  logic               full;
  logic               past_hist;
  logic               anti_fits;

  // Payload state.
  char_t            recent_r [HIST];
  head_t            cur_head_r, cur_head_nxt;
  head_t            hist_head_r [HIST-1];
  col_t             win [CELLS];
  col_t             shift_in [CELLS];
  col_t             load_in [CELLS];
  char_t            rd_data [HIST];
  col_t             rd_col;
  logic [COL_W-1:0] rd_addr;

  // Counting.
  word_t              w_horiz, w_vert, w_diag, w_anti;
  logic [CNT_W-1:0]   c_horiz, c_vert, c_diag, c_anti;
  logic [FOUND_W-1:0] found;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sat_total;

  // Result stage with skid.
  logic               out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0] out_data_r, out_data_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  logic [TOTAL_W-1:0] skid_data_r, skid_data_nxt;
  logic               new_result;
  logic               out_free;

  assign in_stall        = skid_valid_r;
  assign in_acc          = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_match_total = out_data_r;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LEN_RESET;
      word_chars_r <= WORD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_LENGTH: row_length_r <= cfg_wdata[LEN_W-1:0];
        REG_WORD_CHARS: word_chars_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (row_length_r > LEN_W'(MAX_COLS)) begin
      eff_len = LEN_W'(MAX_COLS);
    end else begin
      eff_len = row_length_r;
    end
    for (int i = 0; i < WORD_LEN; i++) begin
      word[i] = (i < 4) ? word_chars_r[8*i +: 8] : '0;
    end
  end

  // ---------------------------------------------------------------- control
  assign row_last  = ({1'b0, col_r} + LEN_W'(1)) >= eff_len;
  assign full      = rows_seen_r == 2'(HIST);
  assign past_hist = col_r >= COL_W'(HIST);
  assign anti_fits = ({1'b0, col_r} + LEN_W'(HIST)) < eff_len;

  always_comb begin
    col_nxt       = col_r;
    rows_seen_nxt = rows_seen_r;
    total_nxt     = total_r;
    if (in_acc) begin
      total_nxt = sat_total;
      if (row_last) begin
        col_nxt = '0;
        if (!full) begin
          rows_seen_nxt = rows_seen_r + 2'd1;
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (in_grid_end) begin
        col_nxt       = '0;
        rows_seen_nxt = '0;
        total_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      rows_seen_r <= '0;
      total_r     <= '0;
    end else begin
      col_r       <= col_nxt;
      rows_seen_r <= rows_seen_nxt;
      total_r     <= total_nxt;
    end
  end

  // ---------------------------------------------------------------- current row history
  always_comb begin
    for (int j = 0; j <= HIST; j++) begin
      cur_head_nxt[j] = (col_r == COL_W'(j)) ? in_cell_char : cur_head_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      recent_r[0] <= in_cell_char;
      for (int k = 1; k < HIST; k++) begin
        recent_r[k] <= recent_r[k-1];
      end
      cur_head_r <= cur_head_nxt;
      if (row_last) begin
        hist_head_r[0] <= cur_head_nxt;
        for (int k = 1; k < HIST - 1; k++) begin
          hist_head_r[k] <= hist_head_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- line stores
  // Reads run five columns ahead of the window centre; at a row end the next row's
  // fifth column is fetched, as the first four come from the saved row heads.
  assign rd_addr = row_last ? COL_W'(HIST + 1) : col_r + COL_W'(HIST + 2);

  for (genvar k = 0; k < HIST; k++) begin : g_line
    char_t wdata;
    if (k == 0) begin : g_first
      assign wdata = in_cell_char;
    end else begin : g_rest
      assign wdata = win[HIST][k-1];
    end
    gws_line_ram u_ram (
      .clk   (clk),
      .we    (in_acc),
      .waddr (col_r),
      .wdata (wdata),
      .re    (in_acc),
      .raddr (rd_addr),
      .rdata (rd_data[k])
    );
  end

  // ---------------------------------------------------------------- window chain
  always_comb begin
    for (int k = 0; k < HIST; k++) begin
      rd_col[k] = rd_data[k];
    end
    for (int p = 0; p < CELLS; p++) begin
      shift_in[p] = (p == CELLS - 1) ? rd_col : win[(p == CELLS - 1) ? p : p + 1];
      load_in[p]  = shift_in[p];
    end
    for (int j = 0; j <= HIST; j++) begin
      load_in[HIST+j][0] = cur_head_nxt[j];
      for (int k = 1; k < HIST; k++) begin
        load_in[HIST+j][k] = hist_head_r[k-1][j];
      end
    end
  end

  for (genvar p = 0; p < CELLS; p++) begin : g_cell
    gws_col_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc && !row_last),
      .load_en  (in_acc && row_last),
      .shift_in (shift_in[p]),
      .load_in  (load_in[p]),
      .col_q    (win[p])
    );
  end

  // ---------------------------------------------------------------- window tests
  always_comb begin
    w_horiz[HIST] = in_cell_char;
    w_vert[HIST]  = in_cell_char;
    w_diag[HIST]  = in_cell_char;
    w_anti[HIST]  = in_cell_char;
    for (int i = 0; i < HIST; i++) begin
      w_horiz[i] = recent_r[HIST-1-i];
      w_vert[i]  = win[HIST][HIST-1-i];
      w_diag[i]  = win[i][HIST-1-i];
      w_anti[i]  = win[CELLS-1-i][HIST-1-i];
    end
  end

  gws_window_test u_horiz (.win(w_horiz), .word(word), .en(past_hist), .cnt(c_horiz));
  gws_window_test u_vert  (.win(w_vert),  .word(word), .en(full), .cnt(c_vert));
  gws_window_test u_diag  (.win(w_diag),  .word(word), .en(full && past_hist), .cnt(c_diag));
  gws_window_test u_anti  (.win(w_anti),  .word(word), .en(full && anti_fits), .cnt(c_anti));

  assign found     = FOUND_W'(c_horiz) + FOUND_W'(c_vert) + FOUND_W'(c_diag)
                   + FOUND_W'(c_anti);
  assign sum       = {1'b0, total_r} + (TOTAL_W + 1)'(found);
  assign sat_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // ---------------------------------------------------------------- result stage
  assign new_result = in_acc && in_grid_end;
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = new_result;
        skid_data_nxt  = sat_total;
      end else begin
        out_valid_nxt = new_result;
        if (new_result) begin
          out_data_nxt = sat_total;
        end
      end
    end else if (new_result) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = sat_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // ---------------------------------------------------------------- assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds an item while the output register is empty");

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && in_grid_end))
    else $error("result appeared without a grid end item");

  a_grid_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_grid_end) |=> (col_r == '0 && rows_seen_r == '0 && total_r == '0))
    else $error("per-grid state not cleared after the grid end");

  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_grid_end) |=> (total_r >= $past(total_r)))
    else $error("running total decreased within a grid");

endmodule

[tb/gws_total_checker.sv]
`timescale 1ns / 100ps
// Checker for the grid word search counter: predicts each grid total and compares the results.
module gws_total_checker
  import gws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_cell_char,
  input  logic                 in_grid_end,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [TOTAL_W-1:0]   out_match_total,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   totals_due
);

  char_t              line_mem [HIST][MAX_COLS];
  char_t              tail [HIST];
  int unsigned        col;
  int unsigned        rows_done;
  int unsigned        top_row;
  logic [TOTAL_W-1:0] running;
  logic [LEN_W-1:0]   len_reg;
  logic [CFG_W-1:0]   word_reg;
  logic [TOTAL_W-1:0] expected_totals [$];
  logic [TOTAL_W-1:0] due_total;

  // A window can match the word read forwards and read backwards.
  function automatic int unsigned window_hits(word_t win);
    int unsigned fwd;
    int unsigned rev;
    fwd = 1;
    rev = 1;
    for (int i = 0; i < WORD_LEN; i++) begin
      if (win[i] != word_reg[8*i +: 8]) fwd = 0;
      if (win[i] != word_reg[8*(WORD_LEN-1-i) +: 8]) rev = 0;
    end
    return fwd + rev;
  endfunction

  function automatic char_t row_above(int unsigned k, int unsigned c);
    int unsigned slot;
    slot = (top_row + HIST - k) % HIST;
    if (c >= MAX_COLS) return 8'h00;
    return line_mem[slot][c];
  endfunction

  task automatic count_cell(input char_t ch, input logic grid_done);
    int unsigned        len;
    int unsigned        c;
    int unsigned        found;
    int unsigned        k;
    logic               row_done;
    logic               full;
    word_t              win;
    logic [TOTAL_W:0]   sum;
    len = (len_reg == 0) ? 1 : ((len_reg > MAX_COLS) ? MAX_COLS : len_reg);
    c = col;
    row_done = (c + 1 >= len);
    full = (rows_done >= HIST);
    found = 0;
    win[HIST] = ch;
    if (c >= HIST) begin
      for (k = 1; k <= HIST; k++) win[HIST-k] = tail[k-1];
      found += window_hits(win);
    end
    if (full) begin
      for (k = 1; k <= HIST; k++) win[HIST-k] = row_above(k, c);
      found += window_hits(win);
      if (c >= HIST) begin
        for (k = 1; k <= HIST; k++) win[HIST-k] = row_above(k, c - k);
        found += window_hits(win);
      end
      if (c + HIST < len) begin
        for (k = 1; k <= HIST; k++) win[HIST-k] = row_above(k, c + k);
        found += window_hits(win);
      end
    end
    sum = {1'b0, running} + (TOTAL_W + 1)'(found);
    running = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];

    // The oldest recent character overwrites the oldest stored row, three columns behind the current one.
    if (c >= HIST) line_mem[top_row][c-HIST] = tail[HIST-1];
    for (k = HIST - 1; k > 0; k--) tail[k] = tail[k-1];
    tail[0] = ch;

    if (row_done) begin
      for (k = 0; k < HIST; k++) begin
        if (c >= k) line_mem[top_row][c-k] = tail[k];
      end
      top_row = (top_row + 1) % HIST;
      if (rows_done < HIST) rows_done++;
      col = 0;
      for (k = 0; k < HIST; k++) tail[k] = '0;
    end else begin
      col = c + 1;
    end

    if (grid_done) begin
      expected_totals = {expected_totals, running};
      for (k = 0; k < HIST; k++) tail[k] = '0;
      col = 0;
      rows_done = 0;
      running = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < HIST; s++) begin
        for (int c = 0; c < MAX_COLS; c++) line_mem[s][c] = '0;
        tail[s] = '0;
      end
      col = 0;
      rows_done = 0;
      top_row = 0;
      running = '0;
      len_reg = ROW_LEN_RESET;
      word_reg = WORD_RESET;
      expected_totals.delete();
      mismatches = 0;
      totals_due = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROW_LENGTH: len_reg = cfg_wdata[LEN_W-1:0];
          REG_WORD_CHARS: word_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) count_cell(in_cell_char, in_grid_end);
      if (out_valid && !out_stall) begin
        if (expected_totals.size() == 0) begin
          $error("match_total: no total expected, got %0d", out_match_total);
          mismatches++;
        end else begin
          due_total = expected_totals.pop_front();
          if (due_total !== out_match_total) begin
            $error("match_total: expected %0d, got %0d", due_total, out_match_total);
            mismatches++;
          end
        end
      end
      totals_due = expected_totals.size();
    end
  end

endmodule

[tb/tb_grid_word_search_counter_unit.sv]
`timescale 1ns / 100ps
// Testbench top for the grid word search counter: clock, reset, grid stimulus and verdict.
module tb_grid_word_search_counter_unit
  import gws_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 14;
  localparam int PHASE_ITEMS    = 60;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_cell_char = '0;
  logic                 in_grid_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TOTAL_W-1:0]   out_match_total;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int               mismatches;
  int               totals_due;
  int               idle_cycles = 0;
  int               items_sent = 0;
  int               hold_request = 0;
  bit               sender_calm = 1'b0;
  bit               receiver_calm = 1'b0;
  logic [LEN_W-1:0] cur_len = ROW_LEN_RESET;
  logic [CFG_W-1:0] cur_word = WORD_RESET;

  logic [LEN_W-1:0] len_table [12] = '{9'd1, 9'd0, 9'd2, 9'd3, 9'd4, 9'd5, 9'd8, 9'd256,
                                       9'd13, 9'd511, 9'd6, 9'd20};
  logic [CFG_W-1:0] word_table [5] = '{WORD_RESET, 32'h4141_4141, 32'h4142_4241,
                                       32'h0000_0000, 32'hFFFF_FFFF};

  always #4 clk = ~clk;

  grid_word_search_counter_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_char    (in_cell_char),
    .in_grid_end     (in_grid_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_total (out_match_total),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  gws_total_checker u_total_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_char    (in_cell_char),
    .in_grid_end     (in_grid_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_total (out_match_total),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .totals_due      (totals_due)
  );

  // Valid is held across back-to-back items and only dropped for a gap.
  task automatic send_cell(input char_t ch, input logic last);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_char <= ch;
    in_grid_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit end_last);
    for (int i = 0; i < s.len(); i++) send_cell(s[i], end_last && (i == s.len() - 1));
  endtask

  // The count of outstanding totals is only read after the edge that takes the last item in.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (totals_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [LEN_W-1:0] len, input logic [CFG_W-1:0] word);
    wait_drained();
    cur_len = len;
    cur_word = word;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ROW_LENGTH;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk);
    cfg_index <= REG_WORD_CHARS;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly letters of the word, so that matches are frequent, with some noise.
  function automatic char_t pick_char();
    if ($urandom_range(0, 99) < 85) return cur_word[8*$urandom_range(0, WORD_LEN-1) +: 8];
    return char_t'($urandom_range(0, 255));
  endfunction

  task automatic run_grid();
    int unsigned eff;
    int unsigned rows;
    int unsigned cells;
    eff = (cur_len == 0) ? 1 : ((cur_len > MAX_COLS) ? MAX_COLS : cur_len);
    if (eff > 40) begin
      // Wide rows: one full row and sometimes part of a second.
      cells = eff + $urandom_range(0, eff / 4);
    end else begin
      if ($urandom_range(0, 4) == 0) rows = $urandom_range(1, 3);
      else rows = (eff > 12) ? $urandom_range(4, 5) : $urandom_range(4, 8);
      cells = rows * eff;
      if ($urandom_range(0, 3) == 0) cells = $urandom_range(1, cells);
    end
    for (int unsigned i = 0; i < cells; i++) send_cell(pick_char(), i == cells - 1);
  endtask

  initial begin
    int stall_len;
    forever begin
      if (hold_request > 0) begin
        stall_len = hold_request;
        hold_request = 0;
      end else begin
        stall_len = receiver_calm ? 0 : $urandom_range(0, 13);
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int phase_start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: a horizontal word both ways, a grid ending mid-row, extreme bytes.
    send_text("XMASAMX", 1'b1);
    send_cell(8'h00, 1'b0);
    send_cell(8'hFF, 1'b1);
    // A square grid holding vertical, diagonal and anti-diagonal occurrences.
    write_config(9'd4, WORD_RESET);
    send_text("XXSXMMMMAAAASXSS", 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      write_config((p < 12) ? len_table[p] : LEN_W'($urandom_range(1, 40)),
                   (p % 6 == 5) ? CFG_W'($urandom) : word_table[p % 6]);
      sender_calm = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_grid();
      if (p == 5) begin
        // Results back up behind a long receiver hold while tiny grids keep arriving.
        wait_drained();
        sender_calm = 1'b1;
        hold_request = 400;
        for (int g = 0; g < 24; g++) begin
          phase_start = $urandom_range(1, 3);
          for (int i = 0; i < phase_start; i++) send_cell(pick_char(), i == phase_start - 1);
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
design/gws_pkg.sv
design/gws_line_ram.sv
design/gws_col_cell.sv
design/gws_window_test.sv
design/grid_word_search_counter_unit.sv
tb/gws_total_checker.sv
tb/tb_grid_word_search_counter_unit.sv
